>>> hw/rtl/swmf_pkg.sv
package swmf_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 11;

  localparam logic [CfgIdxW-1:0] RegWindowSize = 1'd0;
  localparam logic [CfgIdxW-1:0] RegImageWidth = 1'd1;

  localparam logic [2:0]  WinSizeReset  = 3'd5;
  localparam logic [10:0] ImgWidthReset = 11'd512;
  localparam logic [CoordW-1:0] RowLimit = 10'd1023;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic [SampleW-1:0] median;
    logic [CoordW-1:0]  out_row;
    logic [CoordW-1:0]  out_col;
  } out_item_t;

endpackage

>>> hw/rtl/swmf_front.sv
module swmf_front #(
  parameter int unsigned MaxWidth  = 1024,
  parameter int unsigned MaxWindow = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [2:0]                    win_size_i,
  input  logic [10:0]                   img_width_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  swmf_pkg::in_item_t            in_data_i,
  output logic                          col_valid_o,
  input  logic                          col_ready_i,
  output logic [MaxWindow-1:0][swmf_pkg::SampleW-1:0] col_vec_o,
  output logic                          col_emit_o,
  output logic [swmf_pkg::CoordW-1:0]   col_row_o,
  output logic [swmf_pkg::CoordW-1:0]   col_col_o
);
  localparam int unsigned AddrW = $clog2(MaxWidth);
  localparam int unsigned StoreRows = MaxWindow - 1;
  localparam int unsigned WcW = $clog2(MaxWidth + 1);
  localparam int unsigned NW = $clog2(MaxWindow + 1);

  function automatic logic [swmf_pkg::CoordW-1:0] CoordWTrunc(input logic [31:0] v);
    return v[swmf_pkg::CoordW-1:0];
  endfunction

  logic [StoreRows-1:0][swmf_pkg::SampleW-1:0] mem_q [MaxWidth];

  logic [swmf_pkg::CoordW-1:0] col_q, col_d, row_q, row_d;
  logic [swmf_pkg::CoordW-1:0] c, r;
  logic [WcW-1:0] w_eff;
  logic [NW-1:0]  n_eff;

  // stage 1: registered read
  logic                          s1_valid_q;
  logic [swmf_pkg::SampleW-1:0]  s1_sample_q;
  logic [StoreRows-1:0][swmf_pkg::SampleW-1:0] s1_rd_q;
  logic                          s1_emit_q;
  logic [swmf_pkg::CoordW-1:0]   s1_row_q, s1_col_q;
  logic                          adv;

  logic                          wr_pend_q;
  logic [AddrW-1:0]              wr_addr_q;
  logic [StoreRows-1:0][swmf_pkg::SampleW-1:0] wr_vec;

  assign adv        = !s1_valid_q || col_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    if (win_size_i == 3'd0) begin
      n_eff = NW'(1);
    end else if ({29'd0, win_size_i} > 32'(MaxWindow)) begin
      n_eff = NW'(MaxWindow);
    end else begin
      n_eff = NW'(win_size_i);
    end
    if (img_width_i == 11'd0) begin
      w_eff = WcW'(1);
    end else if ({21'd0, img_width_i} > 32'(MaxWidth)) begin
      w_eff = WcW'(MaxWidth);
    end else begin
      w_eff = WcW'(img_width_i);
    end
  end

  always_comb begin
    c = col_q;
    r = row_q;
    if (in_data_i.frame_start) begin
      c = '0;
      r = '0;
    end else if (32'(col_q) >= 32'(w_eff)) begin
      c = '0;
      r = (row_q < swmf_pkg::RowLimit) ? row_q + 1'b1 : row_q;
    end
    col_d = c + 1'b1;
    row_d = r;
    if (32'(c) + 1 >= 32'(w_eff)) begin
      col_d = '0;
      row_d = (r < swmf_pkg::RowLimit) ? r + 1'b1 : r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      wr_pend_q  <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv && in_valid_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      wr_pend_q <= adv && in_valid_i;
    end
  end

  // write back the shifted column in the cycle after its beat
  always_comb begin
    wr_vec[0] = s1_sample_q;
    for (int d = 1; d < StoreRows; d++) begin
      wr_vec[d] = s1_rd_q[d-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      if (wr_pend_q && wr_addr_q == c[AddrW-1:0]) begin
        s1_rd_q <= wr_vec;
      end else begin
        s1_rd_q <= mem_q[c[AddrW-1:0]];
      end
      s1_sample_q <= in_data_i.sample;
      s1_emit_q   <= (32'(r) + 1 >= 32'(n_eff)) && (32'(c) + 1 >= 32'(n_eff));
      s1_row_q    <= CoordWTrunc(32'(r) + 1 - 32'(n_eff));
      s1_col_q    <= CoordWTrunc(32'(c) + 1 - 32'(n_eff));
      wr_addr_q   <= c[AddrW-1:0];
    end
    if (wr_pend_q) begin
      mem_q[wr_addr_q] <= wr_vec;
    end
  end

  always_comb begin
    col_vec_o[0] = s1_sample_q;
    for (int d = 1; d < MaxWindow; d++) begin
      col_vec_o[d] = s1_rd_q[d-1];
    end
  end
  assign col_valid_o = s1_valid_q;
  assign col_emit_o  = s1_emit_q;
  assign col_row_o   = s1_row_q;
  assign col_col_o   = s1_col_q;

endmodule

>>> hw/rtl/swmf_back.sv
module swmf_back #(
  parameter int unsigned MaxWindow = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [2:0]                  win_size_i,
  input  logic                        col_valid_i,
  output logic                        col_ready_o,
  input  logic [MaxWindow-1:0][swmf_pkg::SampleW-1:0] col_vec_i,
  input  logic                        col_emit_i,
  input  logic [swmf_pkg::CoordW-1:0] col_row_i,
  input  logic [swmf_pkg::CoordW-1:0] col_col_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output swmf_pkg::out_item_t         out_data_o
);
  localparam int unsigned Cells = MaxWindow * MaxWindow;
  localparam int unsigned NW = $clog2(MaxWindow + 1);
  localparam int unsigned CntW = $clog2(Cells + 1);

  logic [MaxWindow-1:0][MaxWindow-1:0][swmf_pkg::SampleW-1:0] win_q;
  logic [NW-1:0] n_eff;
  logic adv;

  // stage A: window snapshot; stage B: per-cell less/equal counts; stage C: pick
  logic a_valid_q, a_emit_q;
  logic [MaxWindow-1:0][MaxWindow-1:0][swmf_pkg::SampleW-1:0] a_win_q;
  logic [swmf_pkg::CoordW-1:0] a_row_q, a_col_q, b_row_q, b_col_q;
  logic [NW-1:0] a_n_q;
  logic b_valid_q, b_emit_q;
  logic [Cells-1:0][CntW-1:0] b_lt_q, b_le_q;
  logic [Cells-1:0][swmf_pkg::SampleW-1:0] b_val_q;
  logic [Cells-1:0] b_act_q;
  logic [CntW-1:0] b_rank_q;
  logic o_valid_q;
  swmf_pkg::out_item_t o_data_q;

  assign adv = !o_valid_q || out_ready_i;
  assign col_ready_o = adv;

  always_comb begin
    if (win_size_i == 3'd0) begin
      n_eff = NW'(1);
    end else if ({29'd0, win_size_i} > 32'(MaxWindow)) begin
      n_eff = NW'(MaxWindow);
    end else begin
      n_eff = NW'(win_size_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && col_valid_i) begin
      for (int x = MaxWindow - 1; x > 0; x--) begin
        win_q[x] <= win_q[x-1];
      end
      win_q[0] <= col_vec_i;
      a_win_q[0] <= col_vec_i;
      for (int x = 1; x < MaxWindow; x++) begin
        a_win_q[x] <= win_q[x-1];
      end
      a_emit_q <= col_emit_i;
      a_row_q  <= col_row_i;
      a_col_q  <= col_col_i;
      a_n_q    <= n_eff;
    end
  end

  logic [Cells-1:0] act;
  logic [Cells-1:0][swmf_pkg::SampleW-1:0] vals;
  logic [Cells-1:0][Cells-1:0] lt_m, le_m;
  logic [Cells-1:0][CntW-1:0] lt_c, le_c;
  always_comb begin
    for (int i = 0; i < Cells; i++) begin
      vals[i] = a_win_q[i / MaxWindow][i % MaxWindow];
      act[i]  = (32'(i / MaxWindow) < 32'(a_n_q)) && (32'(i % MaxWindow) < 32'(a_n_q));
    end
    for (int i = 0; i < Cells; i++) begin
      for (int j = 0; j < Cells; j++) begin
        lt_m[i][j] = act[j] && (vals[j] < vals[i]);
        le_m[i][j] = act[j] && (vals[j] <= vals[i]);
      end
      lt_c[i] = CntW'($countones(lt_m[i]));
      le_c[i] = CntW'($countones(le_m[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_lt_q   <= lt_c;
      b_le_q   <= le_c;
      b_val_q  <= vals;
      b_act_q  <= act;
      b_rank_q <= CntW'((32'(a_n_q) * 32'(a_n_q)) >> 1);
      b_emit_q <= a_emit_q;
      b_row_q  <= a_row_q;
      b_col_q  <= a_col_q;
    end
  end

  logic [swmf_pkg::SampleW-1:0] pick;
  always_comb begin
    pick = '0;
    for (int i = 0; i < Cells; i++) begin
      if (b_act_q[i] && b_lt_q[i] <= b_rank_q && b_rank_q < b_le_q[i]) pick = b_val_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= col_valid_i;
      b_valid_q <= a_valid_q && a_emit_q;
      o_valid_q <= b_valid_q && b_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_data_q.median  <= pick;
      o_data_q.out_row <= b_row_q;
      o_data_q.out_col <= b_col_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

endmodule

>>> hw/rtl/sliding_window_median_filter.sv
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | in_item_t (sample, frame_start)
// out     | out | out_valid/out_ready| out_item_t (median, out_row, out_col)
// cfg     | in  | cfg_valid/cfg_ready| cfg_index_i, cfg_data_i
// One sample per cycle sustained while the output does not stall; a result passes the
// line-store read, window, count and pick registers in that order after its input beat.
// The line store is one MaxWidth-deep memory, one read and one write per sample.
// Reset clears positions and valid bits; stored samples are undefined until written.
// A stall on the output holds the whole pipeline; the front takes a new beat as soon as
// its stage register frees.
module sliding_window_median_filter #(
  parameter int unsigned MaxWidth  = 1024,
  parameter int unsigned MaxWindow = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  swmf_pkg::in_item_t      in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output swmf_pkg::out_item_t     out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [swmf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [swmf_pkg::CfgDatW-1:0] cfg_data_i
);
  logic [2:0]  win_size_q;
  logic [10:0] img_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q  <= swmf_pkg::WinSizeReset;
      img_width_q <= swmf_pkg::ImgWidthReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        swmf_pkg::RegWindowSize: win_size_q  <= cfg_data_i[2:0];
        swmf_pkg::RegImageWidth: img_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic col_valid, col_ready, col_emit;
  logic [MaxWindow-1:0][swmf_pkg::SampleW-1:0] col_vec;
  logic [swmf_pkg::CoordW-1:0] col_row, col_col;

  swmf_front #(.MaxWidth(MaxWidth), .MaxWindow(MaxWindow)) u_front (
    .clk_i, .rst_ni,
    .win_size_i(win_size_q), .img_width_i(img_width_q),
    .in_valid_i, .in_ready_o, .in_data_i,
    .col_valid_o(col_valid), .col_ready_i(col_ready), .col_vec_o(col_vec),
    .col_emit_o(col_emit), .col_row_o(col_row), .col_col_o(col_col)
  );

  swmf_back #(.MaxWindow(MaxWindow)) u_back (
    .clk_i, .rst_ni,
    .win_size_i(win_size_q),
    .col_valid_i(col_valid), .col_ready_o(col_ready), .col_vec_i(col_vec),
    .col_emit_i(col_emit), .col_row_i(col_row), .col_col_i(col_col),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

>>> dv/tb_sliding_window_median_filter.sv
`timescale 1ns / 100ps

module tb_sliding_window_median_filter;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  swmf_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  swmf_pkg::out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [swmf_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [swmf_pkg::CfgDatW-1:0] cfg_data_i = '0;

  sliding_window_median_filter dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // filter state mirror
  logic [7:0] line_mem [6][1024];
  logic [7:0] win_mem [7][7];
  int unsigned col_pos, row_pos;
  logic [2:0] win_size_reg = swmf_pkg::WinSizeReset;
  logic [10:0] img_width_reg = swmf_pkg::ImgWidthReset;

  swmf_pkg::out_item_t medians_q[$];
  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;
  bit no_gaps = 1'b0;
  bit frame_pending = 1'b0;
  int hold_seq = 0;
  int hold_len = 0;

  function automatic logic [7:0] pick_rank(logic [7:0] vals[49], int cnt);
    int k, lt, le;
    k = cnt / 2;
    for (int i = 0; i < cnt; i++) begin
      lt = 0;
      le = 0;
      for (int j = 0; j < cnt; j++) begin
        if (vals[j] < vals[i]) lt++;
        if (vals[j] <= vals[i]) le++;
      end
      if (lt <= k && k < le) return vals[i];
    end
    return 8'd0;
  endfunction

  task automatic advance_row();
    col_pos = 0;
    if (row_pos < 1023) row_pos++;
  endtask

  task automatic predict_median(swmf_pkg::in_item_t item);
    int unsigned n, w, c, r, cnt;
    logic [7:0] vert [7];
    logic [7:0] vals [49];
    swmf_pkg::out_item_t res;
    n = (win_size_reg == 0) ? 1 : win_size_reg;
    w = (img_width_reg == 0) ? 1 : (img_width_reg > 1024) ? 1024 : img_width_reg;
    if (item.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end else if (col_pos >= w) begin
      advance_row();
    end
    c = col_pos;
    r = row_pos;
    vert[0] = item.sample;
    for (int d = 1; d < 7; d++) vert[d] = line_mem[d-1][c];
    for (int d = 0; d < 6; d++) line_mem[d][c] = vert[d];
    for (int x = 6; x > 0; x--)
      for (int d = 0; d < 7; d++) win_mem[x][d] = win_mem[x-1][d];
    for (int d = 0; d < 7; d++) win_mem[0][d] = vert[d];
    if (c + 1 >= w) advance_row();
    else col_pos = c + 1;
    if (r + 1 >= n && c + 1 >= n) begin
      cnt = 0;
      for (int x = 0; x < n; x++)
        for (int d = 0; d < n; d++) vals[cnt++] = win_mem[x][d];
      res.median = pick_rank(vals, cnt);
      res.out_row = 10'(r + 1 - n);
      res.out_col = 10'(c + 1 - n);
      medians_q.push_back(res);
    end
  endtask

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(logic [7:0] smp, bit fs);
    int g;
    swmf_pkg::in_item_t item;
    item.sample = smp;
    item.frame_start = fs | frame_pending;
    frame_pending = 1'b0;
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_median(item);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (medians_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [swmf_pkg::CfgIdxW-1:0] idx,
                           logic [swmf_pkg::CfgDatW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == swmf_pkg::RegWindowSize) win_size_reg = val[2:0];
    else img_width_reg = val;
  endtask

  task automatic set_config(int unsigned n, int unsigned w);
    drain_idle();
    write_reg(swmf_pkg::RegWindowSize, swmf_pkg::CfgDatW'(n));
    write_reg(swmf_pkg::RegImageWidth, swmf_pkg::CfgDatW'(w));
    @(posedge clk_i);
    frame_pending = 1'b1;
  endtask

  task automatic send_frame(int unsigned cnt);
    for (int i = 0; i < cnt; i++) send_sample($urandom_range(0, 255), 1'b0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : sink_proc
    int stall;
    int seen;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall = 0;
      seen = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (medians_q.size() == 0) begin
          fail_count++;
          if (mismatch_count++ < 10) $display("unexpected beat %p", out_data_o);
        end else begin
          if (out_data_o !== medians_q[0]) begin
            fail_count++;
            if (mismatch_count++ < 10)
              $display("mismatch exp %p got %p", medians_q[0], out_data_o);
          end
          void'(medians_q.pop_front());
        end
      end
      if (hold_seq != seen) begin
        seen = hold_seq;
        stall = hold_len;
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!no_gaps && $urandom_range(0, 7) == 0) stall = gap_len();
      end
    end
  end

  task automatic test_smallest_window();
    set_config(1, 1);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd128, 1'b0);
    set_config(0, 3);
    send_frame(6);
  endtask

  task automatic test_largest_window();
    set_config(7, 7);
    for (int i = 0; i < 56; i++) send_sample((i % 2) ? 8'd255 : 8'd0, 1'b0);
    set_config(2, 4);
    send_frame(12);
    set_config(4, 5);
    send_frame(25);
  endtask

  task automatic test_width_extremes();
    set_config(1, 0);
    send_frame(5);
    set_config(1, 2047);
    send_frame(20);
    set_config(3, 1024);
    send_frame(30);
  endtask

  task automatic test_frame_restart();
    set_config(3, 5);
    send_frame(17);
    send_sample(8'hA5, 1'b1);
    send_frame(20);
  endtask

  task automatic test_row_saturation();
    set_config(1, 1);
    send_frame(1030);
  endtask

  task automatic test_backpressure();
    set_config(1, 8);
    @(posedge clk_i);
    hold_len <= 300;
    hold_seq <= hold_seq + 1;
    no_gaps = 1'b1;
    send_frame(60);
    no_gaps = 1'b0;
  endtask

  task automatic test_drain_pause();
    set_config(2, 6);
    send_frame(10);
    drain_idle();
    send_frame(10);
  endtask

  task automatic test_random_frames();
    int unsigned sent, n, w, cnt;
    sent = 0;
    while (sent < 100) begin
      n = $urandom_range(0, 7);
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(200, 1024);
        n = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(n, 40);
      end
      set_config(n, w);
      no_gaps = ($urandom_range(0, 4) == 0);
      cnt = w * ((n == 0 ? 1 : n) + $urandom_range(0, 3)) + $urandom_range(0, 5);
      if (cnt > 40) cnt = 40;
      for (int i = 0; i < cnt; i++)
        send_sample($urandom_range(0, 255), $urandom_range(0, 199) == 0);
      sent += cnt;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    for (int d = 0; d < 6; d++)
      for (int c = 0; c < 1024; c++) line_mem[d][c] = 8'd0;
    for (int x = 0; x < 7; x++)
      for (int d = 0; d < 7; d++) win_mem[x][d] = 8'd0;
    col_pos = 0;
    row_pos = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_smallest_window();
    test_largest_window();
    test_width_extremes();
    test_frame_restart();
    test_backpressure();
    test_drain_pause();
    test_row_saturation();
    test_random_frames();
    drain_idle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/swmf_pkg.sv
hw/rtl/swmf_front.sv
hw/rtl/swmf_back.sv
hw/rtl/sliding_window_median_filter.sv
dv/tb_sliding_window_median_filter.sv
